// ----- src/wsp_pkg.sv -----
package wsp_pkg;

	// Port widths of the stream channels.
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 120;
	localparam int M_TUSER_W = 3;

	// Result kinds.
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NOT_RIFF    = 2'd0;
	localparam logic [1:0] ERR_NOT_WAVE    = 2'd1;
	localparam logic [1:0] ERR_EXTENSIBLE  = 2'd2;
	localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

	// Chunk identifiers as little-endian words.
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	// fmt chunk constants.
	localparam logic [31:0] FMT_EXTENSIBLE = 32'd40;
	localparam logic [31:0] FMT_FIELDS     = 32'd16;
	localparam logic [15:0] FORMAT_FLOAT   = 16'd3;

	// One result item.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sample;
		logic [15:0]        channel;
		logic               frame_last;
		logic               data_last;
		logic               is_float;
		logic [15:0]        channel_count;
		logic [31:0]        sample_rate;
		logic [15:0]        bits_per_sample;
		logic [1:0]         error_code;
	} result_t;

endpackage

// ----- src/wsp_parser.sv -----
module wsp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        byte_in,
	input  logic              start_req,
	output logic              res_valid,
	output wsp_pkg::result_t  res
);

	localparam logic [3:0] PH_RIFF     = 4'd0;
	localparam logic [3:0] PH_RSIZE    = 4'd1;
	localparam logic [3:0] PH_WAVE     = 4'd2;
	localparam logic [3:0] PH_ID1      = 4'd3;
	localparam logic [3:0] PH_SZ_SKIP1 = 4'd4;
	localparam logic [3:0] PH_SKIP1    = 4'd5;
	localparam logic [3:0] PH_SZ_FMT   = 4'd6;
	localparam logic [3:0] PH_FMT      = 4'd7;
	localparam logic [3:0] PH_ID2      = 4'd8;
	localparam logic [3:0] PH_SZ_SKIP2 = 4'd9;
	localparam logic [3:0] PH_SKIP2    = 4'd10;
	localparam logic [3:0] PH_SZ_DATA  = 4'd11;
	localparam logic [3:0] PH_DATA     = 4'd12;
	localparam logic [3:0] PH_IDLE     = 4'd13;

	logic [3:0]  phase_q, phase_n;
	logic [1:0]  fc_q, fc_n;
	logic [23:0] shift_q, shift_n;
	logic [31:0] remain_q, remain_n;
	logic [4:0]  fmt_off_q, fmt_off_n;
	logic [15:0] format_q, format_n;
	logic [15:0] chans_q, chans_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] width_q, width_n;
	logic [23:0] acc_q, acc_n;
	logic [1:0]  bis_q, bis_n;
	logic [15:0] chan_q, chan_n;
	logic [17:0] frame_off_q, frame_off_n;
	logic [17:0] fbytes_q, fbytes_n;

	// State as seen by this item: a start request clears everything first.
	logic [3:0]  e_phase;
	logic [1:0]  e_fc;
	logic [23:0] e_shift;
	logic [31:0] e_remain;
	logic [4:0]  e_fmt_off;
	logic [15:0] e_format, e_chans, e_width, e_chan;
	logic [31:0] e_rate;
	logic [23:0] e_acc;
	logic [1:0]  e_bis;
	logic [17:0] e_frame_off, e_fbytes;

	always_comb begin
		if (start_req) begin
			e_phase     = PH_RIFF;
			e_fc        = '0;
			e_shift     = '0;
			e_remain    = '0;
			e_fmt_off   = '0;
			e_format    = '0;
			e_chans     = '0;
			e_rate      = '0;
			e_width     = '0;
			e_acc       = '0;
			e_bis       = '0;
			e_chan      = '0;
			e_frame_off = '0;
			e_fbytes    = '0;
		end else begin
			e_phase     = phase_q;
			e_fc        = fc_q;
			e_shift     = shift_q;
			e_remain    = remain_q;
			e_fmt_off   = fmt_off_q;
			e_format    = format_q;
			e_chans     = chans_q;
			e_rate      = rate_q;
			e_width     = width_q;
			e_acc       = acc_q;
			e_bis       = bis_q;
			e_chan      = chan_q;
			e_frame_off = frame_off_q;
			e_fbytes    = fbytes_q;
		end
	end

	// Four-byte field gathering, shared by all id and size phases.
	logic        field_done;
	logic [31:0] word;
	logic [1:0]  take_fc;
	logic [23:0] take_shift;

	always_comb begin
		field_done = (e_fc == 2'd3);
		word       = {byte_in, e_shift};
		take_fc    = e_fc + 2'd1;
		if (field_done) begin
			take_shift = '0;
		end else begin
			take_shift = e_shift | ({16'b0, byte_in} << {e_fc, 3'b000});
		end
	end

	// Data-phase arithmetic: sample assembly and frame completeness.
	logic [2:0]  bps;
	logic [32:0] at_start;
	logic        frame_ok;
	logic [31:0] acc_full;
	logic [2:0]  bis_inc;
	logic [31:0] remain_dec;
	logic        frame_end;
	logic [31:0] q31;
	logic        width_ok;

	always_comb begin
		bps        = e_width[5:3];
		at_start   = {1'b0, e_remain} + {15'b0, e_frame_off};
		frame_ok   = (e_chans != 16'd0) && (at_start >= {15'b0, e_fbytes});
		acc_full   = {8'b0, e_acc} | ({24'b0, byte_in} << {e_bis, 3'b000});
		bis_inc    = {1'b0, e_bis} + 3'd1;
		remain_dec = e_remain - 32'd1;
		frame_end  = ({1'b0, e_chan} + 17'd1) == {1'b0, e_chans};
		if (e_format == wsp_pkg::FORMAT_FLOAT || e_width == 16'd32) begin
			q31 = acc_full;
		end else if (e_width == 16'd8) begin
			q31 = {acc_full[7:0] ^ 8'h80, 24'b0};
		end else if (e_width == 16'd16) begin
			q31 = {acc_full[15:0], 16'b0};
		end else begin
			q31 = {acc_full[23:0], 8'b0};
		end
	end

	// Next state and result for the current byte.
	always_comb begin
		phase_n     = e_phase;
		fc_n        = e_fc;
		shift_n     = e_shift;
		remain_n    = e_remain;
		fmt_off_n   = e_fmt_off;
		format_n    = e_format;
		chans_n     = e_chans;
		rate_n      = e_rate;
		width_n     = e_width;
		acc_n       = e_acc;
		bis_n       = e_bis;
		chan_n      = e_chan;
		frame_off_n = e_frame_off;
		fbytes_n    = e_fbytes;
		width_ok    = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		res.is_float        = (e_format == wsp_pkg::FORMAT_FLOAT);
		res.channel_count   = e_chans;
		res.sample_rate     = e_rate;
		res.bits_per_sample = e_width;

		unique case (e_phase)
			PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID1, PH_ID2: begin
				fc_n    = take_fc;
				shift_n = take_shift;
				if (field_done) begin
					unique case (e_phase)
						PH_RIFF: begin
							if (word != wsp_pkg::ID_RIFF) begin
								res_valid      = 1'b1;
								res            = '0;
								res.kind       = wsp_pkg::KIND_ERROR;
								res.error_code = wsp_pkg::ERR_NOT_RIFF;
								phase_n        = PH_IDLE;
							end else begin
								phase_n = PH_RSIZE;
							end
						end
						PH_RSIZE: phase_n = PH_WAVE;
						PH_WAVE: begin
							if (word != wsp_pkg::ID_WAVE) begin
								res_valid      = 1'b1;
								res            = '0;
								res.kind       = wsp_pkg::KIND_ERROR;
								res.error_code = wsp_pkg::ERR_NOT_WAVE;
								phase_n        = PH_IDLE;
							end else begin
								phase_n = PH_ID1;
							end
						end
						PH_ID1: phase_n = (word == wsp_pkg::ID_FMT) ? PH_SZ_FMT : PH_SZ_SKIP1;
						default: phase_n = (word == wsp_pkg::ID_DATA) ? PH_SZ_DATA : PH_SZ_SKIP2;
					endcase
				end
			end
			PH_SZ_SKIP1, PH_SZ_SKIP2: begin
				fc_n    = take_fc;
				shift_n = take_shift;
				if (field_done) begin
					remain_n = word;
					if (e_phase == PH_SZ_SKIP1) begin
						phase_n = (word != 32'd0) ? PH_SKIP1 : PH_ID1;
					end else begin
						phase_n = (word != 32'd0) ? PH_SKIP2 : PH_ID2;
					end
				end
			end
			PH_SKIP1, PH_SKIP2: begin
				remain_n = remain_dec;
				if (remain_dec == 32'd0) begin
					phase_n = (e_phase == PH_SKIP1) ? PH_ID1 : PH_ID2;
				end
			end
			PH_SZ_FMT: begin
				fc_n    = take_fc;
				shift_n = take_shift;
				if (field_done) begin
					if (word == wsp_pkg::FMT_EXTENSIBLE) begin
						res_valid      = 1'b1;
						res            = '0;
						res.kind       = wsp_pkg::KIND_ERROR;
						res.error_code = wsp_pkg::ERR_EXTENSIBLE;
						phase_n        = PH_IDLE;
					end else begin
						format_n  = '0;
						chans_n   = '0;
						rate_n    = '0;
						width_n   = '0;
						fmt_off_n = '0;
						remain_n  = (word < wsp_pkg::FMT_FIELDS) ? wsp_pkg::FMT_FIELDS : word;
						phase_n   = PH_FMT;
					end
				end
			end
			PH_FMT: begin
				// Field bytes sit at fixed offsets; bytes past offset 15 are dropped.
				case (e_fmt_off)
					5'd0:  format_n[7:0]   = byte_in;
					5'd1:  format_n[15:8]  = byte_in;
					5'd2:  chans_n[7:0]    = byte_in;
					5'd3:  chans_n[15:8]   = byte_in;
					5'd4:  rate_n[7:0]     = byte_in;
					5'd5:  rate_n[15:8]    = byte_in;
					5'd6:  rate_n[23:16]   = byte_in;
					5'd7:  rate_n[31:24]   = byte_in;
					5'd14: width_n[7:0]    = byte_in;
					5'd15: width_n[15:8]   = byte_in;
					default: ;
				endcase
				if (e_fmt_off != 5'd16) begin
					fmt_off_n = e_fmt_off + 5'd1;
				end
				remain_n = remain_dec;
				if (format_n == wsp_pkg::FORMAT_FLOAT) begin
					width_ok = (width_n == 16'd32);
				end else begin
					width_ok = (width_n == 16'd8) || (width_n == 16'd16) ||
					           (width_n == 16'd24) || (width_n == 16'd32);
				end
				if (remain_dec == 32'd0) begin
					if (!width_ok) begin
						res_valid      = 1'b1;
						res            = '0;
						res.kind       = wsp_pkg::KIND_ERROR;
						res.error_code = wsp_pkg::ERR_UNSUPPORTED;
						phase_n        = PH_IDLE;
					end else begin
						phase_n = PH_ID2;
					end
				end
			end
			PH_SZ_DATA: begin
				fc_n    = take_fc;
				shift_n = take_shift;
				if (field_done) begin
					remain_n    = word;
					chan_n      = '0;
					bis_n       = '0;
					acc_n       = '0;
					frame_off_n = '0;
					fbytes_n    = {2'b0, e_chans} * {15'b0, bps};
					phase_n     = (word != 32'd0) ? PH_DATA : PH_IDLE;
					res_valid   = 1'b1;
					res.kind    = wsp_pkg::KIND_FORMAT;
				end
			end
			PH_DATA: begin
				remain_n    = remain_dec;
				frame_off_n = e_frame_off + 18'd1;
				if (bis_inc == bps) begin
					acc_n  = '0;
					bis_n  = '0;
					chan_n = frame_end ? 16'd0 : (e_chan + 16'd1);
					if (frame_end) begin
						frame_off_n = '0;
					end
					if (frame_ok) begin
						res_valid      = 1'b1;
						res.kind       = wsp_pkg::KIND_SAMPLE;
						res.sample     = q31;
						res.channel    = e_chan;
						res.frame_last = frame_end;
						res.data_last  = frame_end && (remain_dec < {14'b0, e_fbytes});
					end
				end else begin
					acc_n = acc_full[23:0];
					bis_n = bis_inc[1:0];
				end
				if (remain_dec == 32'd0) begin
					phase_n = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	// State registers advance once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			fc_q        <= '0;
			shift_q     <= '0;
			remain_q    <= '0;
			fmt_off_q   <= '0;
			format_q    <= '0;
			chans_q     <= '0;
			rate_q      <= '0;
			width_q     <= '0;
			acc_q       <= '0;
			bis_q       <= '0;
			chan_q      <= '0;
			frame_off_q <= '0;
			fbytes_q    <= '0;
		end else if (in_valid) begin
			phase_q     <= phase_n;
			fc_q        <= fc_n;
			shift_q     <= shift_n;
			remain_q    <= remain_n;
			fmt_off_q   <= fmt_off_n;
			format_q    <= format_n;
			chans_q     <= chans_n;
			rate_q      <= rate_n;
			width_q     <= width_n;
			acc_q       <= acc_n;
			bis_q       <= bis_n;
			chan_q      <= chan_n;
			frame_off_q <= frame_off_n;
			fbytes_q    <= fbytes_n;
		end
	end

endmodule

// ----- src/wsp_out_buf.sv -----
module wsp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsp_pkg::result_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output wsp_pkg::result_t  out_data
);

	logic             head_v_q, skid_v_q;
	wsp_pkg::result_t head_q, skid_q;
	logic             pop;

	assign pop       = head_v_q && out_ready;
	assign full      = head_v_q && skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	// Valid flags of the output register and the skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !head_v_q) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload moves without reset.
	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- src/wav_stream_parser.sv -----
// Channel  Dir  Signals                               Carries
// s_*      in   s_tvalid s_tready s_tdata s_tuser     one file byte and the start flag
// m_*      out  m_tvalid m_tready m_tdata m_tlast m_tuser  one sample, format or error item
//
// One byte per cycle is accepted while s_tready is high; any result is registered for m_*.
// The parser state updates in a single pass between the byte and a two-entry result buffer.
// s_tready drops only while both result entries wait on m_tready.
// arst_n clears the parser to expect the RIFF id and empties the buffer.
// A byte with the start flag set restarts parsing at that byte.
module wav_stream_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wsp_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] byte_in
	input  logic [wsp_pkg::S_TUSER_W-1:0]   s_tuser,  // [0] start_req
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] sample, [47:32] channel, [48] data_last, [64:49] channel_count,
	// [96:65] sample_rate, [112:97] bits_per_sample, [114:113] error_code, rest zero
	output logic [wsp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast,  // frame_last
	output logic [wsp_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] kind, [2] is_float
);

	logic             accept;
	logic             res_valid;
	logic             buf_full;
	wsp_pkg::result_t res;
	wsp_pkg::result_t out_res;

	assign s_tready = !buf_full;
	assign accept   = s_tvalid && s_tready;

	wsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.byte_in   (s_tdata[7:0]),
		.start_req (s_tuser[0]),
		.res_valid (res_valid),
		.res       (res)
	);

	wsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// Pack the result item onto the stream fields.
	assign m_tdata = {5'b0, out_res.error_code, out_res.bits_per_sample, out_res.sample_rate,
	                  out_res.channel_count, out_res.data_last, out_res.channel,
	                  out_res.sample};
	assign m_tlast = out_res.frame_last;
	assign m_tuser = {out_res.is_float, out_res.kind};

endmodule

// ----- src/wsp_checker.sv -----
module wsp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wsp_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tlast,
	input logic [wsp_pkg::M_TUSER_W-1:0]  m_tuser
);

	// A stalled result item holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
	else $error("stalled result item changed");

	// Input is held off only while a result item is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
	else $error("input stalled with no result pending");

	// Only the three defined kinds appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] == wsp_pkg::KIND_SAMPLE ||
		m_tuser[1:0] == wsp_pkg::KIND_FORMAT || m_tuser[1:0] == wsp_pkg::KIND_ERROR)
	else $error("undefined result kind");

	// An error item carries nothing but its code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == wsp_pkg::KIND_ERROR |->
		m_tdata[112:0] == '0 && !m_tlast && !m_tuser[2])
	else $error("error item carries payload");

	// The end of the data chunk always closes a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tlast && m_tuser[1:0] == wsp_pkg::KIND_SAMPLE)
	else $error("data end outside a frame end");

endmodule

bind wav_stream_parser wsp_checker u_wsp_checker (.*);
